[hw/rtl/efd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package efd_pkg;

    localparam logic [7:0] DELIM_BYTE = 8'h7E;
    localparam logic [7:0] ESC_BYTE   = 8'h7D;
    localparam logic [7:0] ESC_XOR    = 8'h20;
    localparam logic [7:0] GOOD_SUM   = 8'hFF;
    localparam logic [7:0] MAX_LENGTH_RESET = 8'hFF;

    localparam logic [1:0] KIND_DATA    = 2'd0;
    localparam logic [1:0] KIND_GOOD    = 2'd1;
    localparam logic [1:0] KIND_BADSUM  = 2'd2;
    localparam logic [1:0] KIND_TOOLONG = 2'd3;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_PAYLOAD,
        PH_CHECK
    } phase_t;

    typedef enum logic [1:0] {
        OP_DATA,
        OP_CHECK,
        OP_TOOLONG
    } op_t;

    // one classified byte handed from the front to the back
    typedef struct packed {
        op_t        op;
        logic [7:0] value;
        logic [7:0] pos;
    } q_entry_t;

endpackage

`default_nettype wire

[hw/rtl/efd_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module efd_front
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [7:0]       rx_byte,
    input  wire logic             cfg_valid,
    input  wire logic [7:0]       cfg_data,
    input  wire logic             q_ready,
    output logic                  q_push,
    output efd_pkg::q_entry_t     q_entry
);

    efd_pkg::phase_t phase_reg, phase_next;
    logic       esc_reg, esc_next;
    logic [7:0] flen_reg, flen_next;
    logic [7:0] cnt_reg, cnt_next;
    logic [7:0] max_len_reg;
    logic [7:0] cnt_inc;
    logic       accept;

    assign in_ready = q_ready;
    assign accept   = in_valid && q_ready;
    assign cnt_inc  = cnt_reg + 8'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= efd_pkg::PH_HUNT;
            esc_reg     <= 1'b0;
            flen_reg    <= '0;
            cnt_reg     <= '0;
            max_len_reg <= efd_pkg::MAX_LENGTH_RESET;
        end
        else
        begin
            phase_reg <= phase_next;
            esc_reg   <= esc_next;
            flen_reg  <= flen_next;
            cnt_reg   <= cnt_next;
            if (cfg_valid)
            begin
                max_len_reg <= cfg_data;
            end
        end
    end

    always_comb
    begin
        logic [7:0] b;
        logic       proceed;

        phase_next = phase_reg;
        esc_next   = esc_reg;
        flen_next  = flen_reg;
        cnt_next   = cnt_reg;
        q_push     = 1'b0;
        q_entry    = '{op: efd_pkg::OP_DATA, value: 8'h00, pos: 8'h00};
        b          = rx_byte;
        proceed    = 1'b0;

        if (accept)
        begin
            if (phase_reg == efd_pkg::PH_HUNT)
            begin
                if (rx_byte == efd_pkg::DELIM_BYTE)
                begin
                    phase_next = efd_pkg::PH_LEN_HI;
                    esc_next   = 1'b0;
                end
            end
            else if (esc_reg)
            begin
                esc_next = 1'b0;
                b        = rx_byte ^ efd_pkg::ESC_XOR;
                proceed  = 1'b1;
            end
            else if (rx_byte == efd_pkg::ESC_BYTE)
            begin
                esc_next = 1'b1;
            end
            else
            begin
                proceed = 1'b1;
            end
        end

        if (proceed)
        begin
            case (phase_reg)
                efd_pkg::PH_LEN_HI:
                begin
                    // high length byte is dropped
                    phase_next = efd_pkg::PH_LEN_LO;
                end
                efd_pkg::PH_LEN_LO:
                begin
                    flen_next = b;
                    if (b > max_len_reg)
                    begin
                        phase_next = efd_pkg::PH_HUNT;
                        q_push     = 1'b1;
                        q_entry    = '{op: efd_pkg::OP_TOOLONG, value: 8'h00, pos: b};
                    end
                    else
                    begin
                        cnt_next   = '0;
                        phase_next = (b == 8'h00) ? efd_pkg::PH_CHECK : efd_pkg::PH_PAYLOAD;
                    end
                end
                efd_pkg::PH_PAYLOAD:
                begin
                    cnt_next = cnt_inc;
                    q_push   = 1'b1;
                    q_entry  = '{op: efd_pkg::OP_DATA, value: b, pos: cnt_reg};
                    if (cnt_inc == flen_reg)
                    begin
                        phase_next = efd_pkg::PH_CHECK;
                    end
                end
                efd_pkg::PH_CHECK:
                begin
                    phase_next = efd_pkg::PH_HUNT;
                    q_push     = 1'b1;
                    q_entry    = '{op: efd_pkg::OP_CHECK, value: b, pos: flen_reg};
                end
                default:
                begin
                    phase_next = efd_pkg::PH_HUNT;
                    esc_next   = 1'b0;
                end
            endcase
        end
    end

    // escape only matters inside a frame
    a_no_esc_in_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        !(phase_reg == efd_pkg::PH_HUNT && esc_reg))
        else $error("escape pending while hunting");

    a_check_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (q_push && q_entry.op == efd_pkg::OP_DATA && cnt_inc == flen_reg)
        |=> phase_reg == efd_pkg::PH_CHECK)
        else $error("last payload byte did not lead to checksum");

endmodule

`default_nettype wire

[hw/rtl/efd_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module efd_queue
#(
    parameter int DEPTH = 2
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire efd_pkg::q_entry_t push_entry,
    output logic                   push_ready,
    input  wire logic              pop,
    output logic                   pop_valid,
    output efd_pkg::q_entry_t      pop_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    efd_pkg::q_entry_t entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             full, empty;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign empty      = (count_reg == '0);
    assign push_ready = !full;
    assign pop_valid  = !empty;
    assign pop_entry  = entries_reg[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

[hw/rtl/efd_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module efd_back
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_valid,
    input  wire efd_pkg::q_entry_t q_entry,
    output logic                   q_pop,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [1:0]             kind,
    output logic [7:0]             data,
    output logic [7:0]             position
);

    logic       out_valid_reg;
    logic [1:0] kind_reg;
    logic [7:0] data_reg, pos_reg;
    logic [7:0] sum_reg, sum_next;
    logic [1:0] kind_next;
    logic [7:0] data_next;
    logic [7:0] total;

    assign q_pop     = q_valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign data      = data_reg;
    assign position  = pos_reg;
    assign total     = sum_reg + q_entry.value;

    always_comb
    begin
        sum_next  = sum_reg;
        kind_next = efd_pkg::KIND_DATA;
        data_next = 8'h00;
        case (q_entry.op)
            efd_pkg::OP_DATA:
            begin
                sum_next  = total;
                data_next = q_entry.value;
            end
            efd_pkg::OP_CHECK:
            begin
                sum_next  = 8'h00;
                kind_next = (total == efd_pkg::GOOD_SUM) ? efd_pkg::KIND_GOOD
                                                         : efd_pkg::KIND_BADSUM;
            end
            efd_pkg::OP_TOOLONG:
            begin
                sum_next  = 8'h00;
                kind_next = efd_pkg::KIND_TOOLONG;
            end
            default:
            begin
                sum_next = 8'h00;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            sum_reg       <= '0;
        end
        else
        begin
            if (q_pop)
            begin
                out_valid_reg <= 1'b1;
                sum_reg       <= sum_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            kind_reg <= kind_next;
            data_reg <= data_next;
            pos_reg  <= q_entry.pos;
        end
    end

    a_sum_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && q_entry.op == efd_pkg::OP_CHECK)
        |=> (sum_reg == 8'h00 && out_valid_reg
             && (kind_reg == efd_pkg::KIND_GOOD || kind_reg == efd_pkg::KIND_BADSUM)))
        else $error("frame end did not clear sum or show status");

    a_end_has_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg != efd_pkg::KIND_DATA) |-> data_reg == 8'h00)
        else $error("end result carries data");

endmodule

`default_nettype wire

[hw/rtl/escaped_frame_deframer.sv]
`timescale 1ns / 1ps
`default_nettype none

// channel  | signals                               | dir | moves
// ---------+---------------------------------------+-----+---------------------------
// in       | in_valid, in_ready, rx_byte           | in  | one raw serial byte
// out      | out_valid, out_ready, kind, data,     | out | payload byte or frame end
//          | position                              |     |
// cfg      | cfg_valid, cfg_ready, cfg_data        | in  | max_length write
//
// one item per cycle sustained while out_ready stays high; each result is registered
// in order: front classifies straight into the queue entry, then the back output register
// in_ready drops only when the queue between front and back is full
// out_ready low stalls the back; the queue absorbs the front for QUEUE_DEPTH items
// reset puts the front in delimiter hunt and sets max_length to 255

module escaped_frame_deframer
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] rx_byte,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [1:0]      kind,
    output logic [7:0]      data,
    output logic [7:0]      position,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [7:0] cfg_data
);

    logic              q_push, q_push_ready, q_pop, q_pop_valid;
    efd_pkg::q_entry_t q_in, q_out;

    assign cfg_ready = 1'b1;

    efd_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .rx_byte   (rx_byte),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .q_ready   (q_push_ready),
        .q_push    (q_push),
        .q_entry   (q_in)
    );

    efd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_in),
        .push_ready (q_push_ready),
        .pop        (q_pop),
        .pop_valid  (q_pop_valid),
        .pop_entry  (q_out)
    );

    efd_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_pop_valid),
        .q_entry   (q_out),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .kind      (kind),
        .data      (data),
        .position  (position)
    );

endmodule

`default_nettype wire

[sim/escaped_frame_deframer_tb.sv]
`timescale 1ns / 1ps

module testbench;

    localparam int SETTLE_CYCLES = 8;
    localparam int NUM_PHASES    = 7;
    localparam int PHASE_BYTES   = 120;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [7:0] position;
    } frame_event_t;

    typedef enum logic {
        ROW_BYTE,
        ROW_MAXLEN
    } row_act_t;

    typedef struct packed {
        row_act_t     act;
        logic [7:0]   value;
        logic         typed;
        frame_event_t ev;
    } row_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] rx_byte;
    logic       out_valid;
    logic       out_ready;
    logic [1:0] kind;
    logic [7:0] data;
    logic [7:0] position;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [7:0] cfg_data;

    // deframer state as seen by the testbench
    efd_pkg::phase_t rx_phase;
    logic       rx_escaped;
    logic [7:0] rx_length;
    logic [7:0] rx_count;
    logic [7:0] rx_sum;
    logic [7:0] max_len_cfg;

    frame_event_t events_due[$];
    row_t         script[$];
    logic [7:0]   line_bytes[$];

    bit no_gaps = 1'b0;
    int mismatches = 0;
    int bytes_in = 0;
    int framed_bytes = 0;
    int n_payload = 0;
    int n_good = 0;
    int n_badsum = 0;
    int n_toolong = 0;

    escaped_frame_deframer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .rx_byte   (rx_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .kind      (kind),
        .data      (data),
        .position  (position),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    function automatic void reset_deframer();
        rx_phase    = efd_pkg::PH_HUNT;
        rx_escaped  = 1'b0;
        rx_length   = 8'h00;
        rx_count    = 8'h00;
        rx_sum      = 8'h00;
        max_len_cfg = efd_pkg::MAX_LENGTH_RESET;
    endfunction

    // advances the state by one raw byte; returns 1 when the byte yields a result
    function automatic bit deframe_byte(input logic [7:0] raw, output frame_event_t ev);
        logic [7:0] b;
        b = raw;
        ev = '0;
        if (rx_phase == efd_pkg::PH_HUNT)
        begin
            // no unescaping while hunting
            if (b == efd_pkg::DELIM_BYTE)
            begin
                rx_phase   = efd_pkg::PH_LEN_HI;
                rx_escaped = 1'b0;
            end
            return 1'b0;
        end
        if (rx_escaped)
        begin
            rx_escaped = 1'b0;
            b = b ^ efd_pkg::ESC_XOR;
        end
        else if (b == efd_pkg::ESC_BYTE)
        begin
            rx_escaped = 1'b1;
            return 1'b0;
        end
        case (rx_phase)
            efd_pkg::PH_LEN_HI:
            begin
                rx_phase = efd_pkg::PH_LEN_LO;
                return 1'b0;
            end
            efd_pkg::PH_LEN_LO:
            begin
                rx_length = b;
                if (b > max_len_cfg)
                begin
                    rx_phase    = efd_pkg::PH_HUNT;
                    ev.kind     = efd_pkg::KIND_TOOLONG;
                    ev.position = b;
                    return 1'b1;
                end
                rx_sum   = 8'h00;
                rx_count = 8'h00;
                rx_phase = (b == 8'h00) ? efd_pkg::PH_CHECK : efd_pkg::PH_PAYLOAD;
                return 1'b0;
            end
            efd_pkg::PH_PAYLOAD:
            begin
                ev.kind     = efd_pkg::KIND_DATA;
                ev.data     = b;
                ev.position = rx_count;
                rx_sum      = rx_sum + b;
                rx_count    = rx_count + 8'd1;
                if (rx_count == rx_length)
                    rx_phase = efd_pkg::PH_CHECK;
                return 1'b1;
            end
            efd_pkg::PH_CHECK:
            begin
                rx_sum      = rx_sum + b;
                rx_phase    = efd_pkg::PH_HUNT;
                ev.kind     = (rx_sum == efd_pkg::GOOD_SUM) ? efd_pkg::KIND_GOOD
                                                            : efd_pkg::KIND_BADSUM;
                ev.position = rx_length;
                return 1'b1;
            end
            default:
            begin
                rx_phase   = efd_pkg::PH_HUNT;
                rx_escaped = 1'b0;
                return 1'b0;
            end
        endcase
    endfunction

    function automatic void plan_byte(input logic [7:0] b);
        row_t r;
        r.act   = ROW_BYTE;
        r.value = b;
        r.typed = 1'b0;
        r.ev    = '0;
        script.push_back(r);
    endfunction

    function automatic void plan_result(input logic [7:0] b, input logic [1:0] k,
                                        input logic [7:0] d, input logic [7:0] p);
        row_t r;
        r.act         = ROW_BYTE;
        r.value       = b;
        r.typed       = 1'b1;
        r.ev.kind     = k;
        r.ev.data     = d;
        r.ev.position = p;
        script.push_back(r);
    endfunction

    function automatic void plan_max_length(input logic [7:0] v);
        row_t r;
        r.act   = ROW_MAXLEN;
        r.value = v;
        r.typed = 1'b0;
        r.ev    = '0;
        script.push_back(r);
    endfunction

    function automatic void stuff_byte(input logic [7:0] b);
        // escape the two reserved codes always, any other byte now and then
        if (b == efd_pkg::DELIM_BYTE || b == efd_pkg::ESC_BYTE || $urandom_range(0, 15) == 0)
        begin
            line_bytes.push_back(efd_pkg::ESC_BYTE);
            line_bytes.push_back(b ^ efd_pkg::ESC_XOR);
        end
        else
            line_bytes.push_back(b);
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic typed,
                             input frame_event_t typed_ev);
        int gap;
        logic got;
        frame_event_t ev;
        gap = no_gaps ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        bytes_in++;
        if (rx_phase != efd_pkg::PH_HUNT || b == efd_pkg::DELIM_BYTE)
            framed_bytes++;
        got = deframe_byte(b, ev);
        if (typed)
            events_due.push_back(typed_ev);
        else if (got)
            events_due.push_back(ev);
    endtask

    task automatic set_max_length(input logic [7:0] v);
        in_valid <= 1'b0;
        while (events_due.size() != 0) @(posedge clk);
        // hunt bytes leave no result, so give the pipeline time to drain
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid   <= 1'b0;
        max_len_cfg = v;
    endtask

    task automatic send_frame();
        int n;
        int len;
        int cap;
        int r;
        int payload_sent;
        int cut;
        logic [7:0] b;
        logic [7:0] sum;
        logic [7:0] chk;
        line_bytes.delete();
        no_gaps = ($urandom_range(0, 3) == 0);
        n = $urandom_range(0, 3);
        repeat (n)
        begin
            b = 8'($urandom);
            if (b == efd_pkg::DELIM_BYTE && $urandom_range(0, 3) != 0)
                b = efd_pkg::ESC_BYTE;
            line_bytes.push_back(b);
        end
        line_bytes.push_back(efd_pkg::DELIM_BYTE);
        stuff_byte(8'($urandom));
        cap = (max_len_cfg < 12) ? max_len_cfg : 12;
        r = $urandom_range(0, 9);
        if (r < 6)
            len = $urandom_range(0, cap);
        else if (r == 6)
            len = $urandom_range(0, max_len_cfg);
        else if (r == 7 && max_len_cfg < 8'hFF)
            len = $urandom_range(max_len_cfg + 1, 255);
        else
            len = $urandom_range(0, 255);
        stuff_byte(len[7:0]);
        // an oversize frame is dropped at its length, so keep its tail short
        payload_sent = (len > max_len_cfg) ? ((len < 4) ? len : 4) : len;
        sum = 8'h00;
        for (int i = 0; i < payload_sent; i++)
        begin
            b = 8'($urandom);
            sum = sum + b;
            stuff_byte(b);
        end
        chk = efd_pkg::GOOD_SUM - sum;
        if ($urandom_range(0, 4) == 0)
            chk = 8'($urandom);
        stuff_byte(chk);
        if ($urandom_range(0, 9) == 0)
        begin
            cut = $urandom_range(1, line_bytes.size() - 1);
            while (line_bytes.size() > cut)
                void'(line_bytes.pop_back());
        end
        foreach (line_bytes[i])
            send_byte(line_bytes[i], 1'b0, '0);
    endtask

    always @(posedge clk)
    begin
        frame_event_t want;
        if (rst_n && out_valid && out_ready)
        begin
            case (kind)
                efd_pkg::KIND_DATA:    n_payload++;
                efd_pkg::KIND_GOOD:    n_good++;
                efd_pkg::KIND_BADSUM:  n_badsum++;
                default:               n_toolong++;
            endcase
            if (events_due.size() == 0)
            begin
                $error("result with none expected: kind %0d data %h position %0d",
                       kind, data, position);
                mismatches++;
            end
            else
            begin
                want = events_due.pop_front();
                if (kind !== want.kind)
                begin
                    $error("kind: expected %0d, got %0d", want.kind, kind);
                    mismatches++;
                end
                if (data !== want.data)
                begin
                    $error("data: expected %h, got %h", want.data, data);
                    mismatches++;
                end
                if (position !== want.position)
                begin
                    $error("position: expected %0d, got %0d", want.position, position);
                    mismatches++;
                end
            end
        end
    end

    // receiver with random stalls, and stretches without any
    initial
    begin
        int stall;
        int stretch_left;
        bit steady;
        stretch_left = 0;
        steady = 1'b0;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (stretch_left == 0)
            begin
                stretch_left = $urandom_range(8, 40);
                steady = ($urandom_range(0, 3) == 0);
            end
            stretch_left--;
            stall = steady ? 0 : $urandom_range(0, 10);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    initial
    begin
        #(64'd5_000_000);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        logic [7:0] limit;
        int phase_start;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        rx_byte   <= 8'h00;
        cfg_valid <= 1'b0;
        cfg_data  <= 8'h00;
        reset_deframer();

        // escape before the delimiter, raw delimiter inside a frame, escaped bytes
        plan_byte(efd_pkg::ESC_BYTE);
        plan_byte(efd_pkg::DELIM_BYTE);
        plan_byte(8'hFF);
        plan_byte(8'h02);
        plan_result(efd_pkg::DELIM_BYTE, efd_pkg::KIND_DATA, 8'h7E, 8'd0);
        plan_byte(efd_pkg::ESC_BYTE);
        plan_result(8'h5D, efd_pkg::KIND_DATA, 8'h7D, 8'd1);
        plan_result(8'h04, efd_pkg::KIND_GOOD, 8'h00, 8'd2);
        // escaped high length byte, then a zero length frame
        plan_byte(efd_pkg::DELIM_BYTE);
        plan_byte(efd_pkg::ESC_BYTE);
        plan_byte(8'h5E);
        plan_byte(8'h00);
        plan_result(8'hFF, efd_pkg::KIND_GOOD, 8'h00, 8'd0);
        // escaped checksum of an ordinary byte, bad sum
        plan_byte(efd_pkg::DELIM_BYTE);
        plan_byte(8'h00);
        plan_byte(8'h01);
        plan_result(8'hFF, efd_pkg::KIND_DATA, 8'hFF, 8'd0);
        plan_byte(efd_pkg::ESC_BYTE);
        plan_result(8'hDF, efd_pkg::KIND_BADSUM, 8'h00, 8'd1);
        plan_max_length(8'h00);
        plan_byte(efd_pkg::DELIM_BYTE);
        plan_byte(8'h55);
        plan_result(8'h01, efd_pkg::KIND_TOOLONG, 8'h00, 8'd1);
        plan_byte(efd_pkg::DELIM_BYTE);
        plan_byte(8'h00);
        plan_byte(8'h00);
        plan_result(8'h00, efd_pkg::KIND_BADSUM, 8'h00, 8'd0);
        plan_max_length(8'hFE);
        plan_byte(efd_pkg::DELIM_BYTE);
        plan_byte(8'h00);
        plan_result(8'hFF, efd_pkg::KIND_TOOLONG, 8'h00, 8'd255);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
        begin
            if (script[i].act == ROW_MAXLEN)
                set_max_length(script[i].value);
            else
                send_byte(script[i].value, script[i].typed, script[i].ev);
        end

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                0:       limit = 8'hFF;
                1:       limit = 8'h00;
                2:       limit = 8'h01;
                3:       limit = 8'hFE;
                4:       limit = 8'($urandom_range(2, 20));
                5:       limit = 8'($urandom);
                default: limit = 8'hFF;
            endcase
            set_max_length(limit);
            phase_start = framed_bytes;
            while (framed_bytes - phase_start < PHASE_BYTES)
                send_frame();
        end

        in_valid <= 1'b0;
        while (events_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("%0d bytes sent (%0d inside frames) over %0d max_length settings",
                 bytes_in, framed_bytes, NUM_PHASES + 2);
        $display("results: %0d payload, %0d good, %0d checksum error, %0d too long",
                 n_payload, n_good, n_badsum, n_toolong);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
